[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge with an
// active-low reset as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property that must hold outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/lltc_pkg.sv]
// ----------------------------------------------------------------------------
// LCD line timing controller package
// Request and response types, mode and request kind codes, register
// addresses and timing constants.
// ----------------------------------------------------------------------------
package lltc_pkg;

  localparam logic [8:0] DOTS_PER_LINE = 9'd456;
  localparam logic [8:0] SCAN_END_DOT  = 9'd80;
  localparam logic [8:0] DRAW_END_DOT  = 9'd252;
  localparam logic [7:0] VISIBLE_LINES = 8'd144;
  localparam logic [7:0] LAST_LINE     = 8'd153;

  localparam logic [7:0] UNMAPPED_DATA = 8'hFF;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_SCAN   = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_e;

  typedef enum logic [15:0] {
    ADDR_CONTROL = 16'hFF40,
    ADDR_STATUS  = 16'hFF41,
    ADDR_SCY     = 16'hFF42,
    ADDR_SCX     = 16'hFF43,
    ADDR_LINE    = 16'hFF44,
    ADDR_CMP     = 16'hFF45,
    ADDR_BGP     = 16'hFF47,
    ADDR_OBP0    = 16'hFF48,
    ADDR_OBP1    = 16'hFF49,
    ADDR_WY      = 16'hFF4A,
    ADDR_WX      = 16'hFF4B
  } addr_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] reg_addr;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] cur_mode;
    logic [7:0] cur_line;
    logic       vblank_irq;
    logic       stat_irq;
    logic       scan_due;
    logic       draw_due;
  } rsp_t;

endpackage

[rtl/lcd_line_timing_controller.sv]
// ----------------------------------------------------------------------------
// LCD line timing controller
// Dot, line and mode sequencing with the LCD register file and the
// vblank and status interrupt pulses.
// ----------------------------------------------------------------------------
// One request (dot tick, register read or register write) is taken per
// clock cycle and gives exactly one response. A request sits in the input
// register while the timing and register logic works on it, then its
// response sits in the result register until it is taken. The only limit
// on throughput is the output side; while the result register is held by
// out_stall_i, one more request is taken into the input register and then
// in_stall_o rises.
module lcd_line_timing_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lltc_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lltc_pkg::rsp_t out_rsp_o
);

  logic           req_valid_q, req_valid_d;
  lltc_pkg::req_t req_q;
  logic           out_valid_q, out_valid_d;
  lltc_pkg::rsp_t out_rsp_q, out_rsp_d;
  logic           in_accept;
  logic           advance;

  logic [8:0]      dot_q, dot_d;
  logic [7:0]      line_q, line_d;
  lltc_pkg::mode_e mode_q, mode_d;
  logic [7:0]      control_q, control_d;
  logic [3:0]      sel_q, sel_d;
  logic            sticky_q, sticky_d;
  logic            eq_q, eq_d;
  logic [7:0]      scy_q, scy_d;
  logic [7:0]      scx_q, scx_d;
  logic [7:0]      cmp_q, cmp_d;
  logic [7:0]      bgp_q, bgp_d;
  logic [7:0]      obp0_q, obp0_d;
  logic [7:0]      obp1_q, obp1_d;
  logic [7:0]      wy_q, wy_d;
  logic [7:0]      wx_q, wx_d;
  logic            prev_q, prev_d;

  logic [8:0] dot_inc;
  logic [7:0] line_inc;
  logic [7:0] status_rd;
  logic       cond;

  logic rsp_vblank;
  logic rsp_at_vblank;
  logic rsp_both_due;
  logic both_held;

  assign advance     = req_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = req_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  assign dot_inc   = dot_q + 9'd1;
  assign line_inc  = line_q + 8'd1;
  assign status_rd = {sticky_q, sel_q, eq_q, mode_q};

  always_comb begin
    req_valid_d = req_valid_q;
    if (in_accept) begin
      req_valid_d = 1'b1;
    end else if (advance) begin
      req_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    dot_d     = dot_q;
    line_d    = line_q;
    mode_d    = mode_q;
    control_d = control_q;
    sel_d     = sel_q;
    sticky_d  = sticky_q;
    eq_d      = eq_q;
    scy_d     = scy_q;
    scx_d     = scx_q;
    cmp_d     = cmp_q;
    bgp_d     = bgp_q;
    obp0_d    = obp0_q;
    obp1_d    = obp1_q;
    wy_d      = wy_q;
    wx_d      = wx_q;
    prev_d    = prev_q;
    cond      = 1'b0;
    out_rsp_d = '0;

    case (req_q.kind)
      lltc_pkg::KIND_TICK: begin
        dot_d = dot_inc;
        case (mode_q)
          lltc_pkg::MODE_SCAN: begin
            if (dot_inc == lltc_pkg::SCAN_END_DOT) begin
              out_rsp_d.scan_due = 1'b1;
              mode_d             = lltc_pkg::MODE_DRAW;
            end
          end
          lltc_pkg::MODE_DRAW: begin
            if (dot_inc == lltc_pkg::DRAW_END_DOT) begin
              out_rsp_d.draw_due = 1'b1;
              mode_d             = lltc_pkg::MODE_HBLANK;
            end
          end
          lltc_pkg::MODE_HBLANK: begin
            if (dot_inc == lltc_pkg::DOTS_PER_LINE) begin
              line_d = line_inc;
              eq_d   = (line_inc == cmp_q);
              if (line_inc == lltc_pkg::VISIBLE_LINES) begin
                mode_d               = lltc_pkg::MODE_VBLANK;
                out_rsp_d.vblank_irq = 1'b1;
              end else begin
                mode_d = lltc_pkg::MODE_SCAN;
              end
              dot_d = '0;
            end
          end
          default: begin
            if (dot_inc == lltc_pkg::DOTS_PER_LINE) begin
              if (line_q == lltc_pkg::LAST_LINE) begin
                line_d = '0;
                mode_d = lltc_pkg::MODE_SCAN;
              end else begin
                line_d = line_inc;
              end
              eq_d  = (line_d == cmp_q);
              dot_d = '0;
            end
          end
        endcase
        cond = (sel_q[0] && mode_d == lltc_pkg::MODE_HBLANK) ||
               (sel_q[1] && mode_d == lltc_pkg::MODE_VBLANK) ||
               (sel_q[2] && mode_d == lltc_pkg::MODE_SCAN) ||
               (sel_q[3] && eq_d);
        out_rsp_d.stat_irq = !prev_q && cond;
        prev_d             = cond;
      end
      lltc_pkg::KIND_READ: begin
        case (req_q.reg_addr)
          lltc_pkg::ADDR_CONTROL: out_rsp_d.read_data = control_q;
          lltc_pkg::ADDR_STATUS:  out_rsp_d.read_data = status_rd;
          lltc_pkg::ADDR_SCY:     out_rsp_d.read_data = scy_q;
          lltc_pkg::ADDR_SCX:     out_rsp_d.read_data = scx_q;
          lltc_pkg::ADDR_LINE:    out_rsp_d.read_data = line_q;
          lltc_pkg::ADDR_CMP:     out_rsp_d.read_data = cmp_q;
          lltc_pkg::ADDR_BGP:     out_rsp_d.read_data = bgp_q;
          lltc_pkg::ADDR_OBP0:    out_rsp_d.read_data = obp0_q;
          lltc_pkg::ADDR_OBP1:    out_rsp_d.read_data = obp1_q;
          lltc_pkg::ADDR_WY:      out_rsp_d.read_data = wy_q;
          lltc_pkg::ADDR_WX:      out_rsp_d.read_data = wx_q;
          default:                out_rsp_d.read_data = lltc_pkg::UNMAPPED_DATA;
        endcase
      end
      lltc_pkg::KIND_WRITE: begin
        case (req_q.reg_addr)
          lltc_pkg::ADDR_CONTROL: begin
            control_d = req_q.write_data;
            if (!req_q.write_data[7]) begin
              mode_d = lltc_pkg::MODE_HBLANK;
              line_d = '0;
            end
          end
          lltc_pkg::ADDR_STATUS: begin
            sel_d    = req_q.write_data[6:3];
            sticky_d = sticky_q | req_q.write_data[7];
          end
          lltc_pkg::ADDR_SCY:  scy_d = req_q.write_data;
          lltc_pkg::ADDR_SCX:  scx_d = req_q.write_data;
          lltc_pkg::ADDR_CMP: begin
            cmp_d = req_q.write_data;
            eq_d  = (line_q == req_q.write_data);
          end
          lltc_pkg::ADDR_BGP:  bgp_d  = req_q.write_data;
          lltc_pkg::ADDR_OBP0: obp0_d = req_q.write_data;
          lltc_pkg::ADDR_OBP1: obp1_d = req_q.write_data;
          lltc_pkg::ADDR_WY:   wy_d   = req_q.write_data;
          lltc_pkg::ADDR_WX:   wx_d   = req_q.write_data;
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    out_rsp_d.cur_mode = mode_d;
    out_rsp_d.cur_line = line_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      dot_q       <= '0;
      line_q      <= '0;
      mode_q      <= lltc_pkg::MODE_SCAN;
      control_q   <= '0;
      sel_q       <= '0;
      sticky_q    <= 1'b0;
      eq_q        <= 1'b0;
      scy_q       <= '0;
      scx_q       <= '0;
      cmp_q       <= '0;
      bgp_q       <= '0;
      obp0_q      <= '0;
      obp1_q      <= '0;
      wy_q        <= '0;
      wx_q        <= '0;
      prev_q      <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        dot_q     <= dot_d;
        line_q    <= line_d;
        mode_q    <= mode_d;
        control_q <= control_d;
        sel_q     <= sel_d;
        sticky_q  <= sticky_d;
        eq_q      <= eq_d;
        scy_q     <= scy_d;
        scx_q     <= scx_d;
        cmp_q     <= cmp_d;
        bgp_q     <= bgp_d;
        obp0_q    <= obp0_d;
        obp1_q    <= obp1_d;
        wy_q      <= wy_d;
        wx_q      <= wx_d;
        prev_q    <= prev_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_req_i;
    end
    if (advance) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign rsp_vblank    = out_valid_q && out_rsp_q.vblank_irq;
  assign rsp_at_vblank = (out_rsp_q.cur_mode == lltc_pkg::MODE_VBLANK) &&
                         (out_rsp_q.cur_line == lltc_pkg::VISIBLE_LINES);
  assign rsp_both_due  = out_valid_q && out_rsp_q.scan_due && out_rsp_q.draw_due;
  assign both_held     = req_valid_q && out_valid_q && out_stall_i;

`include "assert_macros.svh"

  `ASSERT_PROP(a_vblank_line, clk_i, rst_ni, rsp_vblank |-> rsp_at_vblank, "vblank pulse off entry")
  `ASSERT_NEVER(a_scan_draw, clk_i, rst_ni, rsp_both_due, "scan and draw due together")
  `ASSERT_PROP(a_full_stall, clk_i, rst_ni, both_held |-> in_stall_o, "request taken while held")
  `ASSERT_PROP(a_rsp_follows, clk_i, rst_ni, advance |=> out_valid_q, "advanced request lost")

endmodule

[tb/lcd_line_timing_controller_test.sv]
// ----------------------------------------------------------------------------
// LCD line timing controller testbench
// Sends dot ticks, register reads and register writes through the request
// channel with random idle and stall cycles on both sides. Each response is
// compared field by field with a cycle-free timing model of the controller:
// register file access, dot ticks through hblank, a line advance, sprite
// scan and drawing, input backpressure under a long output hold, and mixed
// random traffic.
// ----------------------------------------------------------------------------
module lcd_line_timing_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_NONE      = 2'd3;
  localparam int         LCD_ON_BIT     = 7;
  localparam int         EQ_BIT         = 2;
  localparam int         SEL_HBLANK_BIT = 3;
  localparam int         SEL_VBLANK_BIT = 4;
  localparam int         SEL_SCAN_BIT   = 5;
  localparam int         SEL_CMP_BIT    = 6;
  localparam logic [7:0] STAT_WR_MASK   = 8'hF8;
  localparam logic [7:0] STAT_KEEP_MASK = 8'h87;
  localparam logic [7:0] STAT_ALL_SEL   = 8'h78;
  localparam logic [7:0] CTRL_RUN       = 8'h91;
  localparam int         LINE_TICKS     = 720;
  localparam int         RANDOM_ITEMS   = 160;
  localparam int         HOLD_CYCLES    = 200;
  localparam int         WATCHDOG_CYCLES = 1000;
  localparam int         DRAIN_CYCLES   = 8;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_stall_o;
  lltc_pkg::req_t in_req_i    = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  lltc_pkg::rsp_t out_rsp_o;

  logic [8:0]      dot_cnt   = '0;
  logic [7:0]      line_no   = '0;
  lltc_pkg::mode_e mode_now  = lltc_pkg::MODE_SCAN;
  logic [7:0]      ctrl_reg  = '0;
  logic [7:0]      stat_reg  = {6'd0, lltc_pkg::MODE_SCAN};
  logic [7:0]      scy_reg   = '0;
  logic [7:0]      scx_reg   = '0;
  logic [7:0]      cmp_reg   = '0;
  logic [7:0]      bgp_reg   = '0;
  logic [7:0]      obp0_reg  = '0;
  logic [7:0]      obp1_reg  = '0;
  logic [7:0]      wy_reg    = '0;
  logic [7:0]      wx_reg    = '0;
  logic            stat_prev = 1'b0;

  lltc_pkg::rsp_t lcd_rsp_q[$];
  int unsigned    mismatch_count = 0;
  int unsigned    quiet_cycles   = 0;
  int unsigned    hold_left      = 0;
  int unsigned    stall_left     = 0;
  bit             req_fire_q     = 1'b0;
  bit             rsp_fire_q     = 1'b0;
  bit             hold_ask       = 1'b0;
  bit             tx_idle        = 1'b1;
  bit             rx_idle        = 1'b1;

  lcd_line_timing_controller i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic void enter_lcd_mode(lltc_pkg::mode_e m);
    mode_now = m;
    stat_reg[1:0] = m;
  endfunction

  function automatic void refresh_eq();
    stat_reg[EQ_BIT] = (line_no == cmp_reg);
  endfunction

  function automatic lltc_pkg::rsp_t advance_lcd(lltc_pkg::req_t r);
    lltc_pkg::rsp_t o;
    logic cond;
    o = '0;
    case (r.kind)
      lltc_pkg::KIND_TICK: begin
        dot_cnt = dot_cnt + 9'd1;
        case (mode_now)
          lltc_pkg::MODE_SCAN: if (dot_cnt == lltc_pkg::SCAN_END_DOT) begin
            o.scan_due = 1'b1;
            enter_lcd_mode(lltc_pkg::MODE_DRAW);
          end
          lltc_pkg::MODE_DRAW: if (dot_cnt == lltc_pkg::DRAW_END_DOT) begin
            o.draw_due = 1'b1;
            enter_lcd_mode(lltc_pkg::MODE_HBLANK);
          end
          lltc_pkg::MODE_HBLANK: if (dot_cnt == lltc_pkg::DOTS_PER_LINE) begin
            line_no = line_no + 8'd1;
            refresh_eq();
            if (line_no == lltc_pkg::VISIBLE_LINES) begin
              enter_lcd_mode(lltc_pkg::MODE_VBLANK);
              o.vblank_irq = 1'b1;
            end else begin
              enter_lcd_mode(lltc_pkg::MODE_SCAN);
            end
            dot_cnt = '0;
          end
          default: if (dot_cnt == lltc_pkg::DOTS_PER_LINE) begin
            if (line_no == lltc_pkg::LAST_LINE) begin
              line_no = '0;
              enter_lcd_mode(lltc_pkg::MODE_SCAN);
            end else begin
              line_no = line_no + 8'd1;
            end
            refresh_eq();
            dot_cnt = '0;
          end
        endcase
        cond = (stat_reg[SEL_HBLANK_BIT] && mode_now == lltc_pkg::MODE_HBLANK) ||
               (stat_reg[SEL_VBLANK_BIT] && mode_now == lltc_pkg::MODE_VBLANK) ||
               (stat_reg[SEL_SCAN_BIT] && mode_now == lltc_pkg::MODE_SCAN) ||
               (stat_reg[SEL_CMP_BIT] && stat_reg[EQ_BIT]);
        o.stat_irq = !stat_prev && cond;
        stat_prev = cond;
      end
      lltc_pkg::KIND_READ: begin
        case (r.reg_addr)
          lltc_pkg::ADDR_CONTROL: o.read_data = ctrl_reg;
          lltc_pkg::ADDR_STATUS:  o.read_data = stat_reg;
          lltc_pkg::ADDR_SCY:     o.read_data = scy_reg;
          lltc_pkg::ADDR_SCX:     o.read_data = scx_reg;
          lltc_pkg::ADDR_LINE:    o.read_data = line_no;
          lltc_pkg::ADDR_CMP:     o.read_data = cmp_reg;
          lltc_pkg::ADDR_BGP:     o.read_data = bgp_reg;
          lltc_pkg::ADDR_OBP0:    o.read_data = obp0_reg;
          lltc_pkg::ADDR_OBP1:    o.read_data = obp1_reg;
          lltc_pkg::ADDR_WY:      o.read_data = wy_reg;
          lltc_pkg::ADDR_WX:      o.read_data = wx_reg;
          default:                o.read_data = lltc_pkg::UNMAPPED_DATA;
        endcase
      end
      lltc_pkg::KIND_WRITE: begin
        case (r.reg_addr)
          lltc_pkg::ADDR_CONTROL: begin
            ctrl_reg = r.write_data;
            if (!r.write_data[LCD_ON_BIT]) begin
              enter_lcd_mode(lltc_pkg::MODE_HBLANK);
              line_no = '0;
            end
          end
          lltc_pkg::ADDR_STATUS: begin
            stat_reg = (r.write_data & STAT_WR_MASK) | (stat_reg & STAT_KEEP_MASK);
          end
          lltc_pkg::ADDR_SCY:    scy_reg = r.write_data;
          lltc_pkg::ADDR_SCX:    scx_reg = r.write_data;
          lltc_pkg::ADDR_CMP: begin
            cmp_reg = r.write_data;
            refresh_eq();
          end
          lltc_pkg::ADDR_BGP:    bgp_reg = r.write_data;
          lltc_pkg::ADDR_OBP0:   obp0_reg = r.write_data;
          lltc_pkg::ADDR_OBP1:   obp1_reg = r.write_data;
          lltc_pkg::ADDR_WY:     wy_reg = r.write_data;
          lltc_pkg::ADDR_WX:     wx_reg = r.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
    o.cur_mode = mode_now;
    o.cur_line = line_no;
    return o;
  endfunction

  function automatic lltc_pkg::req_t tick_req();
    lltc_pkg::req_t r;
    r = '0;
    r.kind = lltc_pkg::KIND_TICK;
    return r;
  endfunction

  function automatic lltc_pkg::req_t read_req(logic [15:0] addr);
    lltc_pkg::req_t r;
    r = '0;
    r.kind = lltc_pkg::KIND_READ;
    r.reg_addr = addr;
    return r;
  endfunction

  function automatic lltc_pkg::req_t write_req(logic [15:0] addr, logic [7:0] data);
    lltc_pkg::req_t r;
    r.kind = lltc_pkg::KIND_WRITE;
    r.reg_addr = addr;
    r.write_data = data;
    return r;
  endfunction

  function automatic lltc_pkg::req_t random_req();
    lltc_pkg::req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.reg_addr = 16'($urandom);
    r.write_data = 8'($urandom);
    if (pick < 55) r.kind = lltc_pkg::KIND_TICK;
    else if (pick < 72) r.kind = lltc_pkg::KIND_READ;
    else if (pick < 94) r.kind = lltc_pkg::KIND_WRITE;
    else r.kind = KIND_NONE;
    if ($urandom_range(0, 9) < 8)
      r.reg_addr = 16'(lltc_pkg::ADDR_CONTROL + $urandom_range(0, 11));
    if (r.kind == lltc_pkg::KIND_WRITE && r.reg_addr == lltc_pkg::ADDR_CONTROL &&
        $urandom_range(0, 3) != 0)
      r.write_data[LCD_ON_BIT] = 1'b1;
    return r;
  endfunction

  task automatic send_req(lltc_pkg::req_t r);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!req_fire_q);
    lcd_rsp_q.push_back(advance_lcd(r));
  endtask

  task automatic note_mismatch(string field, int unsigned want, int unsigned got);
    $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
    mismatch_count++;
  endtask

  task automatic test_register_access();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_req(read_req(lltc_pkg::ADDR_CONTROL));
    send_req(read_req(lltc_pkg::ADDR_STATUS));
    send_req(read_req(lltc_pkg::ADDR_LINE));
    send_req(read_req(16'hFF46));
    send_req(read_req(16'h0000));
    send_req(read_req(16'hFFFF));
    send_req('{kind: KIND_NONE, reg_addr: 16'hFFFF, write_data: 8'hFF});
    send_req(write_req(lltc_pkg::ADDR_SCY, 8'hFF));
    send_req(write_req(lltc_pkg::ADDR_SCX, 8'hFF));
    send_req(write_req(lltc_pkg::ADDR_CMP, 8'hFF));
    send_req(write_req(lltc_pkg::ADDR_BGP, 8'hFF));
    send_req(write_req(lltc_pkg::ADDR_OBP0, 8'hFF));
    send_req(write_req(lltc_pkg::ADDR_OBP1, 8'hFF));
    send_req(write_req(lltc_pkg::ADDR_WY, 8'hFF));
    send_req(write_req(lltc_pkg::ADDR_WX, 8'hFF));
    send_req(write_req(lltc_pkg::ADDR_STATUS, 8'hFF));
    send_req(read_req(lltc_pkg::ADDR_STATUS));
    send_req(write_req(lltc_pkg::ADDR_STATUS, 8'h00));
    send_req(read_req(lltc_pkg::ADDR_STATUS));
    send_req(write_req(lltc_pkg::ADDR_LINE, 8'hFF));
    send_req(write_req(16'hFF46, 8'hFF));
    send_req(write_req(16'hFFFF, 8'h00));
    send_req(write_req(lltc_pkg::ADDR_CONTROL, 8'hFF));
    send_req(read_req(lltc_pkg::ADDR_CONTROL));
    send_req(write_req(lltc_pkg::ADDR_CONTROL, 8'h00));
    send_req(read_req(lltc_pkg::ADDR_CMP));
    send_req(read_req(lltc_pkg::ADDR_WX));
  endtask

  task automatic test_line_timing();
    lltc_pkg::req_t poke;
    send_req(write_req(lltc_pkg::ADDR_CMP, 8'($urandom_range(0, 1))));
    send_req(write_req(lltc_pkg::ADDR_STATUS, STAT_ALL_SEL));
    send_req(write_req(lltc_pkg::ADDR_CONTROL, 8'h00));
    send_req(write_req(lltc_pkg::ADDR_CONTROL, CTRL_RUN));
    for (int n = 0; n < LINE_TICKS; n++) begin
      tx_idle = n < 256;
      rx_idle = tx_idle;
      if ($urandom_range(0, 255) == 0) begin
        case ($urandom_range(0, 2))
          0: poke = read_req(16'(lltc_pkg::ADDR_CONTROL + $urandom_range(0, 11)));
          1: poke = write_req(lltc_pkg::ADDR_STATUS, 8'($urandom));
          default: poke = write_req(lltc_pkg::ADDR_CMP, 8'($urandom_range(0, 1)));
        endcase
        send_req(poke);
      end
      send_req(tick_req());
    end
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    hold_ask = 1'b1;
    repeat (40) send_req(random_req());
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
      end
      send_req(random_req());
    end
  endtask

  always @(negedge clk_i) begin : check_rsp
    lltc_pkg::rsp_t want;
    req_fire_q = rst_ni && in_valid_i && !in_stall_o;
    rsp_fire_q = rst_ni && out_valid_o && !out_stall_i;
    if (rsp_fire_q) begin
      if (lcd_rsp_q.size() == 0) begin
        $display("%0t: unexpected response, expected none, got 0x%0h", $time, out_rsp_o);
        mismatch_count++;
      end else begin
        want = lcd_rsp_q.pop_front();
        if (out_rsp_o.read_data !== want.read_data)
          note_mismatch("read_data", want.read_data, out_rsp_o.read_data);
        if (out_rsp_o.cur_mode !== want.cur_mode)
          note_mismatch("cur_mode", want.cur_mode, out_rsp_o.cur_mode);
        if (out_rsp_o.cur_line !== want.cur_line)
          note_mismatch("cur_line", want.cur_line, out_rsp_o.cur_line);
        if (out_rsp_o.vblank_irq !== want.vblank_irq)
          note_mismatch("vblank_irq", want.vblank_irq, out_rsp_o.vblank_irq);
        if (out_rsp_o.stat_irq !== want.stat_irq)
          note_mismatch("stat_irq", want.stat_irq, out_rsp_o.stat_irq);
        if (out_rsp_o.scan_due !== want.scan_due)
          note_mismatch("scan_due", want.scan_due, out_rsp_o.scan_due);
        if (out_rsp_o.draw_due !== want.draw_due)
          note_mismatch("draw_due", want.draw_due, out_rsp_o.draw_due);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_ask) begin
      hold_ask = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (rsp_fire_q) stall_left = rx_idle ? $urandom_range(0, 11) : 0;
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (req_fire_q || rsp_fire_q) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("lcd_line_timing_controller: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_register_access();
    test_line_timing();
    test_backpressure();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (lcd_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("lcd_line_timing_controller: match");
    end else begin
      $display("lcd_line_timing_controller: mismatch");
    end
    $finish;
  end

endmodule

[lcd_line_timing_controller.f]
+incdir+rtl
rtl/lltc_pkg.sv
rtl/lcd_line_timing_controller.sv
tb/lcd_line_timing_controller_test.sv
